// ===== rtl/core/ptp_nco_pkg.sv =====
// ----------------------------------------------------------------------------
// ptp_nco_pkg: shared types and constants for the pilot tone PLL/NCO
// CORDIC angle table, command struct, loop constants and Q1.15 rounding.
// ----------------------------------------------------------------------------
package ptp_nco_pkg;

    localparam int unsigned DW = 34;          // CORDIC datapath width

    localparam logic [17:0] CP_Q16 = 18'd174719;   // 2.666 in Q.16
    localparam logic [17:0] CI_Q16 = 18'd232980;   // 3.555 in Q.16
    localparam logic signed [DW-1:0] ROT_START = 34'sd652032875;

    // register indexes
    localparam logic [1:0] REG_STEP  = 2'd0;
    localparam logic [1:0] REG_SCALE = 2'd1;
    localparam logic [1:0] REG_BAND  = 2'd2;

    typedef struct packed {
        logic start;
        logic vectoring;
    } t_cor_cmd;

    function automatic logic [31:0] angle(input logic [4:0] idx);
        logic [31:0] a;
        unique case (idx)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933406;
            5'd2:  a = 32'd167458907;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667331;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10679838;
            5'd7:  a = 32'd5340245;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            5'd20: a = 32'd652;
            5'd21: a = 32'd326;
            5'd22: a = 32'd163;
            5'd23: a = 32'd81;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

    // Q.30 to Q1.15, round half up, saturate
    function automatic logic signed [15:0] q30_to_q15(input logic signed [DW-1:0] v);
        logic signed [DW:0] s;
        logic signed [DW-15:0] r;
        logic signed [15:0] o;
        s = {v[DW-1], v} + (DW+1)'(16384);
        r = s[DW:15];
        if (r > (DW-14)'(32767))       o = 16'sd32767;
        else if (r < -(DW-14)'(32768)) o = -16'sd32768;
        else                           o = r[15:0];
        return o;
    endfunction

endpackage

// ===== rtl/core/pilot_tone_pll_nco.sv =====
// ----------------------------------------------------------------------------
// pilot_tone_pll_nco: second-order PLL and NCO locking to a pilot tone
// Mixer, CORDIC phase detector, PI loop filter, NCO and harmonic output.
// ----------------------------------------------------------------------------
// Each sample transfer runs one item at a time through a small sequencer: eight
// multiplies on one registered multiplier and three passes of a shared
// iterative CORDIC (atan2 detector, feedback cos/sin and output cosine), plus
// three update steps, the sample transfer and the output load. A new sample
// is taken only once the last one has gone through. A sample whose mixer
// products are both zero skips the detector pass. o_sample_ready is high only
// when the core is idle; a finished result sits in an output register until
// transferred, so the next sample is taken while it waits. If that register is
// still full when the next result is ready, the core stalls until it empties.
// Configuration writes are taken at any cycle with i_cfg_we high and should
// only be issued while the core is idle; an index of 3 is ignored.
// ----------------------------------------------------------------------------
module pilot_tone_pll_nco #(
    parameter int unsigned CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_sample_valid,
    output logic               o_sample_ready,
    input  logic signed [15:0] i_sample,
    output logic               o_nco_out_valid,
    input  logic               i_nco_out_ready,
    output logic signed [15:0] o_nco_out,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [30:0]        i_cfg_data
);
    localparam int unsigned DW = ptp_nco_pkg::DW;

    // multiply operations, in issue order
    localparam logic [2:0] OP_BB   = 3'd0;  // band^2
    localparam logic [2:0] OP_KI   = 3'd1;  // ki gain
    localparam logic [2:0] OP_KP   = 3'd2;  // kp gain
    localparam logic [2:0] OP_MIXC = 3'd3;  // sample * cos
    localparam logic [2:0] OP_MIXS = 3'd4;  // sample * sin
    localparam logic [2:0] OP_DINT = 3'd5;  // ki * err
    localparam logic [2:0] OP_DPRP = 3'd6;  // kp * err
    localparam logic [2:0] OP_HARM = 3'd7;  // total * nco_scale

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL   = 9'b000000010,
        S_VEC   = 9'b000000100,
        S_UPD1  = 9'b000001000,
        S_UPD2  = 9'b000010000,
        S_UPD3  = 9'b000100000,
        S_RSTRT = 9'b001000000,
        S_ROT   = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

    t_state r_state;

    // configuration
    logic [30:0] r_step;
    logic [3:0]  r_scale;
    logic [23:0] r_band;

    // loop state
    logic [31:0]        r_int, r_est, r_base;
    logic signed [15:0] r_fc, r_fs;

    // working registers
    logic signed [15:0]   r_smp;
    logic [2:0]           r_op;
    logic [1:0]           r_sub;
    logic signed [32:0]   r_ma, r_mb;
    logic signed [65:0]   r_p;
    logic [29:0]          r_bb;
    logic [31:0]          r_ki;
    logic [25:0]          r_kp;
    logic signed [DW-1:0] r_xm;
    logic [31:0]          r_err, r_dint, r_dprop, r_total;
    logic                 r_flip, r_second;
    logic signed [15:0]   r_res, r_out;
    logic                 r_ovalid;

    // CORDIC hookup
    ptp_nco_pkg::t_cor_cmd cmd;
    logic signed [DW-1:0]  cx, cy, cz, ox, oy, oz;
    logic                  cdone;

    // combinational helpers
    logic signed [65:0]   p_r15, p_r29, p_r23;
    logic signed [DW-1:0] yv, xneg, yneg, cxf, cyf;
    logic [31:0]          rot_chk, rot_ph;
    logic                 rot_flip;

    assign p_r15 = r_p + 66'sd32768;
    assign p_r29 = r_p + (66'sd1 <<< 29);
    assign p_r23 = r_p + (66'sd1 <<< 23);
    assign yv    = -r_p[DW-1:0];
    assign xneg  = -r_xm;
    assign yneg  = r_p[DW-1:0];

    assign rot_chk  = r_total + 32'h4000_0000;
    assign rot_flip = rot_chk[31];
    assign rot_ph   = rot_flip ? (r_total + 32'h8000_0000) : r_total;

    assign cxf = r_flip ? -ox : ox;
    assign cyf = r_flip ? -oy : oy;

    always_comb begin
        cmd = '0;
        cx  = r_xm;
        cy  = yv;
        cz  = '0;
        if (r_state == S_MUL && r_sub == 2'd2 && r_op == OP_MIXS
                && !(r_xm == '0 && yv == '0)) begin
            cmd.start     = 1'b1;
            cmd.vectoring = 1'b1;
            // left half plane: rotate by half a turn first
            if (r_xm < 0) begin
                cx = xneg;
                cy = yneg;
                cz = DW'(33'h0_8000_0000);
            end
        end else if (r_state == S_RSTRT) begin
            cmd.start = 1'b1;
            cx        = ptp_nco_pkg::ROT_START;
            cy        = '0;
            cz        = DW'(signed'(rot_ph));
        end
    end

    ptp_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_x     (cx),
        .i_y     (cy),
        .i_z     (cz),
        .o_done  (cdone),
        .o_x     (ox),
        .o_y     (oy),
        .o_z     (oz)
    );

    // shared multiplier, registered
    always_ff @(posedge i_clk) begin
        r_p <= r_ma * r_mb;
    end

    // operand select for the current op
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL && r_sub == 2'd0) begin
            unique case (r_op)
                OP_BB: begin
                    r_ma <= 33'(r_band);
                    r_mb <= 33'(r_band);
                end
                OP_KI: begin
                    r_ma <= 33'(r_bb);
                    r_mb <= 33'(ptp_nco_pkg::CI_Q16);
                end
                OP_KP: begin
                    r_ma <= 33'(r_band);
                    r_mb <= 33'(ptp_nco_pkg::CP_Q16);
                end
                OP_MIXC: begin
                    r_ma <= 33'(r_smp);
                    r_mb <= 33'(r_fc);
                end
                OP_MIXS: begin
                    r_ma <= 33'(r_smp);
                    r_mb <= 33'(r_fs);
                end
                OP_DINT: begin
                    r_ma <= 33'(r_ki);
                    r_mb <= 33'(signed'(r_err));
                end
                OP_DPRP: begin
                    r_ma <= 33'(r_kp);
                    r_mb <= 33'(signed'(r_err));
                end
                OP_HARM: begin
                    r_ma <= 33'(r_total);
                    r_mb <= 33'(r_scale);
                end
                default: begin
                    r_ma <= '0;
                    r_mb <= '0;
                end
            endcase
        end
    end

    // sequencer and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= 31'd340018244;
            r_scale  <= 4'd2;
            r_band   <= 24'd167772;
            r_int    <= '0;
            r_est    <= '0;
            r_base   <= '0;
            r_fc     <= 16'sd32767;
            r_fs     <= '0;
            r_ovalid <= 1'b0;
            r_op     <= OP_BB;
            r_sub    <= '0;
            r_second <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ptp_nco_pkg::REG_STEP:  r_step  <= i_cfg_data;
                    ptp_nco_pkg::REG_SCALE: r_scale <= i_cfg_data[3:0];
                    ptp_nco_pkg::REG_BAND:  r_band  <= i_cfg_data[23:0];
                    default: ;
                endcase
            end
            // S_FIN reloads the slot itself
            if (r_ovalid && i_nco_out_ready && r_state != S_FIN) r_ovalid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_sample_valid) begin
                        r_smp   <= i_sample;
                        r_op    <= OP_BB;
                        r_sub   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_sub != 2'd2) begin
                        r_sub <= r_sub + 2'd1;
                    end else begin
                        r_sub <= '0;
                        r_op  <= r_op + 3'd1;
                        unique case (r_op)
                            OP_BB:   r_bb  <= r_p[47:18];
                            OP_KI:   r_ki  <= p_r15[47:16];
                            OP_KP:   r_kp  <= p_r15[41:16];
                            OP_MIXC: r_xm  <= r_p[DW-1:0];
                            OP_MIXS: begin
                                if (r_xm == '0 && yv == '0) begin
                                    r_err <= '0;         // no signal, no error
                                end else begin
                                    r_state <= S_VEC;
                                end
                            end
                            OP_DINT: r_dint <= p_r29[61:30];
                            OP_DPRP: begin
                                r_dprop <= p_r23[55:24];
                                r_state <= S_UPD1;
                            end
                            OP_HARM: begin
                                r_total  <= r_p[31:0];
                                r_second <= 1'b1;
                                r_state  <= S_RSTRT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_VEC: begin
                    if (cdone) begin
                        r_err   <= oz[31:0];
                        r_op    <= OP_DINT;
                        r_state <= S_MUL;
                    end
                end
                S_UPD1: begin
                    r_int   <= r_int + r_dint;
                    r_base  <= r_base + 32'(r_step);
                    r_state <= S_UPD2;
                end
                S_UPD2: begin
                    r_est   <= r_est + r_dprop + r_int;
                    r_state <= S_UPD3;
                end
                S_UPD3: begin
                    r_total  <= r_base + r_est;
                    r_second <= 1'b0;
                    r_state  <= S_RSTRT;
                end
                S_RSTRT: begin
                    r_flip  <= rot_flip;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (cdone) begin
                        if (r_second) begin
                            r_res   <= ptp_nco_pkg::q30_to_q15(cxf);
                            r_state <= S_FIN;
                        end else begin
                            r_fc    <= ptp_nco_pkg::q30_to_q15(cxf);
                            r_fs    <= ptp_nco_pkg::q30_to_q15(cyf);
                            r_op    <= OP_HARM;
                            r_sub   <= '0;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_FIN: begin
                    // output slot free or emptying this cycle
                    if (!r_ovalid || i_nco_out_ready) begin
                        r_out    <= r_res;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_sample_ready  = (r_state == S_IDLE);
    assign o_nco_out_valid = r_ovalid;
    assign o_nco_out       = r_out;
endmodule

// ===== rtl/core/ptp_cordic.sv =====
// ----------------------------------------------------------------------------
// ptp_cordic: iterative CORDIC, one micro-rotation per clock
// Shared between atan2 (vectoring) and cos/sin (rotation) passes.
// ----------------------------------------------------------------------------
module ptp_cordic #(
    parameter int unsigned STAGES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ptp_nco_pkg::t_cor_cmd               i_cmd,
    input  logic signed [ptp_nco_pkg::DW-1:0]   i_x,
    input  logic signed [ptp_nco_pkg::DW-1:0]   i_y,
    input  logic signed [ptp_nco_pkg::DW-1:0]   i_z,
    output logic                                o_done,
    output logic signed [ptp_nco_pkg::DW-1:0]   o_x,
    output logic signed [ptp_nco_pkg::DW-1:0]   o_y,
    output logic signed [ptp_nco_pkg::DW-1:0]   o_z
);
    localparam int unsigned IW = (STAGES > 1) ? $clog2(STAGES) : 1;

    logic                              r_busy, r_vec, r_done;
    logic [IW-1:0]                     r_i;
    logic signed [ptp_nco_pkg::DW-1:0] r_x, r_y, r_z;
    logic signed [ptp_nco_pkg::DW-1:0] xs, ys, ang;
    logic                              up;

    assign xs  = r_x >>> r_i;
    assign ys  = r_y >>> r_i;
    assign ang = ptp_nco_pkg::DW'(ptp_nco_pkg::angle(5'(r_i)));
    // anticlockwise step when vectoring with y not above zero, or rotating with z >= 0
    assign up  = r_vec ? (r_y <= 0) : (r_z >= 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_i == IW'(STAGES - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_z   <= i_z;
            r_vec <= i_cmd.vectoring;
            r_i   <= '0;
        end else if (r_busy) begin
            if (up) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - ang;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + ang;
            end
            r_i <= r_i + IW'(1);
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
endmodule
